### hw/rtl/akbd_pkg.sv
// Shared types, constants and helpers for the additive keystream byte decryptor.
package akbd_pkg;

    localparam int KEY_IDX_W  = 8;
    localparam int KEY_BITS   = 32;

    // Key bytes at or past this index are dropped; the index saturates here.
    localparam logic [KEY_IDX_W-1:0] KEY_BLOCK_BYTES = 8'd187;

    localparam logic [KEY_IDX_W-1:0] KEY_POSITIONS [KEY_BITS] = '{
         8'd20,  8'd52, 8'd111,  8'd10,  8'd27,  8'd71, 8'd142,  8'd53,
         8'd82, 8'd138,   8'd1,  8'd78,  8'd86, 8'd121, 8'd183,  8'd85,
        8'd105, 8'd152,  8'd39, 8'd140, 8'd172,  8'd11,  8'd64, 8'd144,
        8'd155,   8'd6,  8'd71, 8'd163, 8'd186,  8'd49, 8'd126,  8'd43
    };

    // One input item after the input register.
    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
        logic       key_start;
        logic       stream_restart;
        logic       block_start;
        logic [1:0] align;
    } item_t;

    // Which bit of the key byte feeds step key bit i.
    function automatic logic [2:0] key_bit_sel(input int unsigned i);
        int unsigned t;
        t = i * 5 + 3;
        return t[2:0];
    endfunction

endpackage

### hw/rtl/akbd_key_builder.sv
// Step key assembly from key-material bytes, indexed through the position table.
module akbd_key_builder (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                key_en,
    input  akbd_pkg::item_t                     item,
    output logic [akbd_pkg::KEY_BITS-1:0]       step_key
);

    logic [akbd_pkg::KEY_BITS-1:0]  step_key_reg, step_key_next;
    logic [akbd_pkg::KEY_IDX_W-1:0] key_idx_reg, key_idx_next;
    logic [akbd_pkg::KEY_BITS-1:0]  key_base;
    logic [akbd_pkg::KEY_IDX_W-1:0] idx_base;

    always_comb begin
        key_base      = item.key_start ? '0 : step_key_reg;
        idx_base      = item.key_start ? '0 : key_idx_reg;
        step_key_next = key_base;
        key_idx_next  = idx_base;
        if (idx_base < akbd_pkg::KEY_BLOCK_BYTES) begin
            for (int i = 0; i < akbd_pkg::KEY_BITS; i++) begin
                if (akbd_pkg::KEY_POSITIONS[i] == idx_base) begin
                    step_key_next[i] = key_base[i] |
                                       item.data_byte[akbd_pkg::key_bit_sel(i)];
                end
            end
            key_idx_next = idx_base + 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_key_reg <= '0;
            key_idx_reg  <= '0;
        end else if (key_en) begin
            step_key_reg <= step_key_next;
            key_idx_reg  <= key_idx_next;
        end
    end

    assign step_key = step_key_reg;

    a_idx_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        key_idx_reg <= akbd_pkg::KEY_BLOCK_BYTES)
        else $error("key byte index ran past the key block");

    a_key_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !key_en |=> $stable(step_key_reg) && $stable(key_idx_reg))
        else $error("step key changed without a key item");

    a_key_start_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        key_en && item.key_start |=> key_idx_reg == 8'd1)
        else $error("key start did not restart the byte index");

endmodule

### hw/rtl/akbd_keystream.sv
// Keystream counter, word and byte phase; XORs one cipher byte per item.
module akbd_keystream (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                data_en,
    input  akbd_pkg::item_t                     item,
    input  logic [akbd_pkg::KEY_BITS-1:0]       step_key,
    output logic [7:0]                          plain_byte
);

    logic [31:0] counter_reg, counter_next;
    logic [31:0] word_reg, word_next;
    logic [1:0]  phase_reg, phase_next;
    logic [31:0] ctr_base;
    logic [1:0]  phase_cur;
    logic [31:0] prev_word;
    logic [7:0]  ks_byte;

    always_comb begin
        ctr_base  = item.stream_restart ? step_key : counter_reg;
        phase_cur = item.block_start ? item.align : phase_reg;
        prev_word = ctr_base - step_key;
        word_next    = word_reg;
        counter_next = ctr_base;
        if (item.block_start && item.align != 2'd0) begin
            word_next = prev_word;
        end
        // Phase zero takes a fresh word and advances the counter.
        if (phase_cur == 2'd0) begin
            word_next    = ctr_base;
            counter_next = ctr_base + step_key;
        end
        unique case (phase_cur)
            2'd0: ks_byte = word_next[7:0];
            2'd1: ks_byte = word_next[15:8];
            2'd2: ks_byte = word_next[23:16];
            2'd3: ks_byte = word_next[31:24];
            default: ks_byte = word_next[7:0];
        endcase
        phase_next = phase_cur + 2'd1;
        plain_byte = item.data_byte ^ ks_byte;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg <= '0;
            word_reg    <= '0;
            phase_reg   <= '0;
        end else if (data_en) begin
            counter_reg <= counter_next;
            word_reg    <= word_next;
            phase_reg   <= phase_next;
        end
    end

    a_phase_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        data_en && !item.block_start |=> phase_reg == $past(phase_reg) + 2'd1)
        else $error("byte phase did not advance");

    a_counter_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        data_en && phase_cur != 2'd0 |=> counter_reg == $past(ctr_base))
        else $error("counter moved in the middle of a word");

    a_hold_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !data_en |=> $stable(counter_reg) && $stable(word_reg) && $stable(phase_reg))
        else $error("keystream state changed without a cipher item");

endmodule

### hw/rtl/additive_keystream_byte_decryptor.sv
// Top level: input register, key builder, keystream unit and output register.
//
// Accepts one item per clock while not stalled. Mode-0 (key) items update the
// step key and give no result; each mode-1 (cipher) item gives one plain
// byte, which passes through the input register and then the output register.
// The step key absorb and the single 32-bit counter add complete in the cycle
// an item leaves the input register, so back-to-back items see the state left
// by their predecessor. Input stalls only while the output holds an untaken
// byte and a cipher item waits behind it.
module additive_keystream_byte_decryptor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // data_byte[7:0], align[9:8], zero[15:10]
    input  logic [3:0]  s_tuser,   // mode[0], key_start[1], stream_restart[2], block_start[3]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // plain_byte[7:0]
);

    logic                          in_valid_reg;
    akbd_pkg::item_t               item_reg;
    logic                          out_valid_reg;
    logic [7:0]                    out_data_reg;
    logic                          advance;
    logic                          key_en;
    logic                          data_en;
    logic [akbd_pkg::KEY_BITS-1:0] step_key;
    logic [7:0]                    plain_byte;

    // Key items never need the output register; cipher items wait for room.
    assign advance  = in_valid_reg && (!item_reg.mode || !out_valid_reg || m_tready);
    assign key_en   = advance && !item_reg.mode;
    assign data_en  = advance && item_reg.mode;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.mode           <= s_tuser[0];
            item_reg.data_byte      <= s_tdata[7:0];
            item_reg.key_start      <= s_tuser[1];
            item_reg.stream_restart <= s_tuser[2];
            item_reg.block_start    <= s_tuser[3];
            item_reg.align          <= s_tdata[9:8];
        end
    end

    akbd_key_builder u_key (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .key_en   (key_en),
        .item     (item_reg),
        .step_key (step_key)
    );

    akbd_keystream u_ks (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .data_en    (data_en),
        .item       (item_reg),
        .step_key   (step_key),
        .plain_byte (plain_byte)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (data_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (data_en) begin
            out_data_reg <= plain_byte;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_cipher_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        data_en |=> out_valid_reg)
        else $error("cipher item produced no result");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && item_reg.mode && out_valid_reg && !m_tready)
        else $error("input stalled without a blocked cipher item");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        data_en |-> !out_valid_reg || m_tready)
        else $error("untaken result overwritten");

endmodule

### tb/sv/additive_keystream_byte_decryptor_tb.sv
// Self-checking testbench: directed table, then random key runs, cipher blocks and single random items.
module additive_keystream_byte_decryptor_tb;

    localparam int N_ITEMS     = 1750;
    localparam int CALM_ITEMS  = 250;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        akbd_pkg::item_t it;
        bit              typed;
        logic [7:0]      plain;
    } stim_row_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;  // data_byte[7:0], align[9:8], zero[15:10]
    logic [3:0]  s_tuser  = '0;  // mode[0], key_start[1], stream_restart[2], block_start[3]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;       // plain_byte[7:0]

    // Predicted block state
    logic [31:0] step_key   = '0;
    logic [31:0] ks_counter = '0;
    logic [31:0] ks_word    = '0;
    logic [1:0]  ks_phase   = '0;
    logic [7:0]  key_idx    = '0;

    logic [7:0]  plain_q[$];
    stim_row_t   stim_table[$];

    int  items_done  = 0;
    int  n_checked   = 0;
    int  key_loads   = 0;
    int  errors      = 0;
    int  cycle_count = 0;
    bit  calm        = 1'b0;
    bit  hold_done   = 1'b0;

    additive_keystream_byte_decryptor i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes pending", cycle_count,
                     plain_q.size());
            $display("additive_keystream_byte_decryptor: mismatch");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        if (errors < 20)
            $display("cycle %0d: %s", cycle_count, what);
        errors = errors + 1;
    endtask

    // Advance the predicted state by one item; returns 1 when a plain byte results.
    function automatic bit decrypt_step(input akbd_pkg::item_t it, output logic [7:0] plain);
        logic [7:0] ks_byte;
        plain = '0;
        items_done = items_done + 1;
        if (!it.mode) begin
            if (it.key_start) begin
                key_idx  = '0;
                step_key = '0;
                key_loads = key_loads + 1;
            end
            // drop key bytes past the key block; the index saturates
            if (key_idx < akbd_pkg::KEY_BLOCK_BYTES) begin
                for (int i = 0; i < akbd_pkg::KEY_BITS; i++) begin
                    if (akbd_pkg::KEY_POSITIONS[i] == key_idx)
                        step_key[i] = step_key[i] | it.data_byte[(i * 5 + 3) % 8];
                end
                key_idx = key_idx + 8'd1;
            end
            return 1'b0;
        end
        if (it.stream_restart)
            ks_counter = step_key;
        if (it.block_start) begin
            ks_phase = it.align;
            // mid-word entry continues the previous word
            if (it.align != 2'd0)
                ks_word = ks_counter - step_key;
        end
        if (ks_phase == 2'd0) begin
            ks_word    = ks_counter;
            ks_counter = ks_counter + step_key;
        end
        ks_byte  = ks_word[8 * ks_phase +: 8];
        ks_phase = ks_phase + 2'd1;
        plain    = it.data_byte ^ ks_byte;
        return 1'b1;
    endfunction

    function automatic stim_row_t row(input bit mode, input logic [7:0] data,
                                      input bit kst, input bit rst, input bit bst,
                                      input logic [1:0] align, input bit typed = 1'b0,
                                      input logic [7:0] plain = 8'h00);
        stim_row_t r;
        r.it.mode           = mode;
        r.it.data_byte      = data;
        r.it.key_start      = kst;
        r.it.stream_restart = rst;
        r.it.block_start    = bst;
        r.it.align          = align;
        r.typed             = typed;
        r.plain             = plain;
        return r;
    endfunction

    // Offer one item, wait for it to be taken, then record what it should produce.
    task automatic drive_item(input akbd_pkg::item_t it, input bit typed,
                              input logic [7:0] want);
        logic [7:0] pb;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, it.align, it.data_byte};
        s_tuser  <= {it.block_start, it.stream_restart, it.key_start, it.mode};
        do @(posedge aclk); while (!s_tready);
        if (decrypt_step(it, pb))
            plain_q.push_back(typed ? want : pb);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    // Result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (plain_q.size() == 0) begin
                report_mismatch($sformatf("plain byte %02h with nothing pending", m_tdata));
            end else begin
                if (m_tdata !== plain_q[0])
                    report_mismatch($sformatf("plain byte %02h, predicted %02h",
                                              m_tdata, plain_q[0]));
                void'(plain_q.pop_front());
                n_checked = n_checked + 1;
            end
        end
    end

    // Receiver: short random stalls, one long hold-off, none near the end
    initial begin
        wait (aresetn);
        forever begin
            if (!hold_done && items_done >= HOLD_AT) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++)
                    @(posedge aclk);
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    initial begin
        akbd_pkg::item_t it;
        logic [31:0]     r;
        int              len;
        int              pick;
        bit              lead;
        bit              rst;
        bit              bst;

        // After reset step key and counter are zero: cipher bytes pass through.
        stim_table.push_back(row(1, 8'h00, 0, 0, 0, 2'd0, 1, 8'h00));
        stim_table.push_back(row(1, 8'hFF, 0, 0, 1, 2'd3, 1, 8'hFF));
        stim_table.push_back(row(1, 8'h5A, 0, 1, 1, 2'd0, 1, 8'h5A));
        // Key run of all-ones bytes reaching the lowest table positions
        stim_table.push_back(row(0, 8'hFF, 1, 0, 0, 2'd0));
        for (int k = 1; k < 12; k++)
            stim_table.push_back(row(0, 8'hFF, 0, 0, 0, 2'd0));
        // cipher-side control bits on a key byte are ignored
        stim_table.push_back(row(0, 8'h00, 0, 1, 1, 2'd3));
        stim_table.push_back(row(1, 8'h00, 0, 1, 1, 2'd0));
        stim_table.push_back(row(1, 8'hFF, 0, 0, 0, 2'd0));
        stim_table.push_back(row(1, 8'h00, 0, 0, 1, 2'd2));
        // key start on a cipher byte is ignored
        stim_table.push_back(row(1, 8'hA5, 1, 0, 0, 2'd0));
        // restart alone reloads the counter but keeps the byte phase
        stim_table.push_back(row(1, 8'h3C, 0, 1, 0, 2'd0));
        // mid-word block start right after a restart uses a zero word
        stim_table.push_back(row(1, 8'hC3, 0, 1, 1, 2'd1, 1, 8'hC3));
        stim_table.push_back(row(1, 8'h00, 0, 0, 0, 2'd0));
        stim_table.push_back(row(1, 8'h00, 0, 0, 0, 2'd0));
        stim_table.push_back(row(1, 8'h00, 0, 0, 0, 2'd0));
        // key byte with no start mark ORs into the step key
        stim_table.push_back(row(0, 8'hAA, 0, 0, 0, 2'd0));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (stim_table[n])
            drive_item(stim_table[n].it, stim_table[n].typed, stim_table[n].plain);

        while (items_done < N_ITEMS) begin
            if (items_done >= N_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
                // key run, sometimes past the end of the key block
                len  = ($urandom_range(0, 3) == 0) ? $urandom_range(185, 195)
                                                    : $urandom_range(4, 60);
                lead = ($urandom_range(0, 7) != 0);
                for (int k = 0; k < len; k++) begin
                    r            = $urandom;
                    it           = r[$bits(akbd_pkg::item_t)-1:0];
                    it.mode      = 1'b0;
                    it.key_start = (k == 0) && lead;
                    drive_item(it, 1'b0, 8'h00);
                end
            end else if (pick < 9) begin
                len = $urandom_range(1, 12);
                rst = ($urandom_range(0, 3) == 0);
                bst = ($urandom_range(0, 7) != 0);
                for (int k = 0; k < len; k++) begin
                    r                 = $urandom;
                    it                = r[$bits(akbd_pkg::item_t)-1:0];
                    it.mode           = 1'b1;
                    it.stream_restart = (k == 0) && rst;
                    it.block_start    = (k == 0) && bst;
                    drive_item(it, 1'b0, 8'h00);
                end
            end else begin
                r  = $urandom;
                it = r[$bits(akbd_pkg::item_t)-1:0];
                drive_item(it, 1'b0, 8'h00);
            end
        end
        calm = 1'b1;
        s_tvalid <= 1'b0;

        while (plain_q.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("sent %0d items incl. %0d key loads; checked %0d plain bytes",
                 items_done, key_loads, n_checked);
        $display("receiver held off %0d cycles once; %0d errors", HOLD_CYCLES, errors);
        if (errors == 0)
            $display("additive_keystream_byte_decryptor: match");
        else
            $display("additive_keystream_byte_decryptor: mismatch");
        $finish;
    end

endmodule
